/* design/rbsi_pkg.sv */
// package for the ray / box slab intersection unit: request, response and divider types
package rbsi_pkg;

    // divider geometry: 33-bit distance magnitude shifted up by 16, padded to a step multiple
    localparam int DIV_BITS   = 52;
    localparam int DIV_STEP   = 4;
    localparam int DIV_STAGES = DIV_BITS / DIV_STEP;
    localparam int REM_BITS   = 32;

    // total register stages from request to response
    localparam int PIPE_DEPTH = DIV_STAGES + 5;

    // largest and smallest Q16.16 times
    localparam logic signed [31:0] T_LARGEST  = 32'sh7FFF_FFFF;
    localparam logic signed [31:0] T_SMALLEST = 32'sh8000_0000;

    typedef struct packed {
        logic signed [31:0] origin_x;
        logic signed [31:0] origin_y;
        logic signed [31:0] origin_z;
        logic signed [31:0] dir_x;
        logic signed [31:0] dir_y;
        logic signed [31:0] dir_z;
        logic signed [31:0] box_min_x;
        logic signed [31:0] box_min_y;
        logic signed [31:0] box_min_z;
        logic signed [31:0] box_max_x;
        logic signed [31:0] box_max_y;
        logic signed [31:0] box_max_z;
    } t_ray_req;

    typedef struct packed {
        logic        hit;
        logic [30:0] entry_time;
    } t_hit_rsp;

    // one divider stage's working state
    typedef struct packed {
        logic [REM_BITS-1:0] rem;
        logic [DIV_BITS-1:0] num;
        logic [DIV_BITS-1:0] quo;
        logic [REM_BITS-1:0] den;
    } t_div_state;

    // per-request flags carried alongside the dividers
    typedef struct packed {
        logic [5:0] qneg;
        logic [2:0] par;
        logic       pmiss;
    } t_side;

endpackage

/* design/rbsi_div.sv */
// pipelined restoring divider, unsigned, a few quotient bits per stage
module rbsi_div (
    input  logic                          i_clk,
    input  logic                          i_en,
    input  logic [rbsi_pkg::DIV_BITS-1:0] i_num,
    input  logic [rbsi_pkg::REM_BITS-1:0] i_den,
    output logic [rbsi_pkg::DIV_BITS-1:0] o_quo
);
    import rbsi_pkg::*;

    t_div_state r_st [DIV_STAGES];
    t_div_state n_st [DIV_STAGES];

    // a group of restoring steps, one quotient bit each
    function automatic t_div_state div_steps(input t_div_state s);
        t_div_state        v;
        logic [REM_BITS:0] trial;
        v = s;
        for (int k = 0; k < DIV_STEP; k++) begin
            trial = {v.rem, v.num[DIV_BITS-1]};
            v.num = {v.num[DIV_BITS-2:0], 1'b0};
            if (trial >= {1'b0, v.den}) begin
                trial = trial - {1'b0, v.den};
                v.quo = {v.quo[DIV_BITS-2:0], 1'b1};
            end else begin
                v.quo = {v.quo[DIV_BITS-2:0], 1'b0};
            end
            v.rem = trial[REM_BITS-1:0];
        end
        return v;
    endfunction

    // stage chain
    for (genvar g = 0; g < DIV_STAGES; g++) begin : g_stage
        if (g == 0) begin : g_first
            t_div_state seed;
            always_comb begin
                seed.rem = '0;
                seed.num = i_num;
                seed.quo = '0;
                seed.den = i_den;
                n_st[g]  = div_steps(seed);
            end
        end else begin : g_next
            always_comb begin
                n_st[g] = div_steps(r_st[g-1]);
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_st[g] <= n_st[g];
            end
        end
    end

    assign o_quo = r_st[DIV_STAGES-1].quo;

endmodule

/* design/ray_box_slab_intersect_unit.sv */
// top level of the ray / axis-aligned box slab intersection unit
//
// usage
//   request channel: i_req_valid / o_req_ready carry one ray and one box per
//   request (signed Q16.16 origin, direction, lower and upper corners).
//   response channel: o_rsp_valid / i_rsp_ready carry the hit flag and the
//   nearest non-negative entry time (unsigned Q15.16, 0 on a miss).
//   throughput: one request per cycle while the receiver does not stall.
//   pipeline: 18 register stages, the first loaded at the accept: set-up, the
//   six slab quotients in pipelined dividers of 13 stages, four quotient bits
//   per stage, then saturation, ordering, narrowing and output.
//   all stages advance together; when the receiver stalls with a response
//   waiting, o_req_ready drops and the whole pipeline holds its contents.
//   empty stages are filled while the output slot is free.
//   reset: synchronous active-low i_rst_n clears all valid bits; no
//   response is presented until a new request has passed the pipeline.
//   no configuration and no state is kept between requests.
module ray_box_slab_intersect_unit (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_req_valid,
    output logic               o_req_ready,
    input  rbsi_pkg::t_ray_req i_req,
    output logic               o_rsp_valid,
    input  logic               i_rsp_ready,
    output rbsi_pkg::t_hit_rsp o_rsp
);
    import rbsi_pkg::*;

    logic                   en;
    logic [PIPE_DEPTH-1:0]  r_v;

    // set-up stage signals
    logic signed [31:0]     ax_o   [3];
    logic signed [31:0]     ax_d   [3];
    logic signed [31:0]     ax_lo  [3];
    logic signed [31:0]     ax_hi  [3];
    logic signed [32:0]     slab_dist [6];
    logic [32:0]            n_nmag [6];
    logic [31:0]            n_dmag [6];
    logic [32:0]            r_nmag [6];
    logic [31:0]            r_dmag [6];
    t_side                  n_side;
    t_side                  r_side [DIV_STAGES+1];
    logic [DIV_BITS-1:0]    quo    [6];

    // post-divider stages
    logic signed [31:0]     n_t    [6];
    logic signed [31:0]     r_t    [6];
    logic                   r_s1_pmiss;
    logic [2:0]             r_s1_par;
    logic signed [31:0]     n_lo   [3];
    logic signed [31:0]     n_hi   [3];
    logic signed [31:0]     r_lo   [3];
    logic signed [31:0]     r_hi   [3];
    logic                   r_s2_pmiss;
    logic signed [31:0]     n_near;
    logic signed [31:0]     n_far;
    logic signed [31:0]     r_near;
    logic signed [31:0]     r_far;
    logic                   r_s3_pmiss;
    t_hit_rsp               n_rsp;
    t_hit_rsp               r_rsp;

    // global advance: pipeline moves unless the output is blocked
    assign en          = !r_v[PIPE_DEPTH-1] || i_rsp_ready;
    assign o_req_ready = en;
    assign o_rsp_valid = r_v[PIPE_DEPTH-1];
    assign o_rsp       = r_rsp;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else if (en) begin
            r_v <= {r_v[PIPE_DEPTH-2:0], i_req_valid};
        end
    end

    // axis views of the request
    always_comb begin
        ax_o[0]  = i_req.origin_x;  ax_o[1]  = i_req.origin_y;  ax_o[2]  = i_req.origin_z;
        ax_d[0]  = i_req.dir_x;     ax_d[1]  = i_req.dir_y;     ax_d[2]  = i_req.dir_z;
        ax_lo[0] = i_req.box_min_x; ax_lo[1] = i_req.box_min_y; ax_lo[2] = i_req.box_min_z;
        ax_hi[0] = i_req.box_max_x; ax_hi[1] = i_req.box_max_y; ax_hi[2] = i_req.box_max_z;
    end

    // slab distances, magnitudes, quotient signs and parallel tests
    always_comb begin
        n_side.pmiss = 1'b0;
        for (int a = 0; a < 3; a++) begin
            slab_dist[2*a]   = {ax_lo[a][31], ax_lo[a]} - {ax_o[a][31], ax_o[a]};
            slab_dist[2*a+1] = {ax_hi[a][31], ax_hi[a]} - {ax_o[a][31], ax_o[a]};
            n_side.par[a] = (ax_d[a] == '0);
            if (n_side.par[a] && ((ax_o[a] < ax_lo[a]) || (ax_o[a] > ax_hi[a]))) begin
                n_side.pmiss = 1'b1;
            end
            for (int k = 0; k < 2; k++) begin
                n_nmag[2*a+k] = slab_dist[2*a+k][32] ? 33'(-slab_dist[2*a+k])
                                                     : 33'(slab_dist[2*a+k]);
                n_dmag[2*a+k] = ax_d[a][31] ? 32'(-ax_d[a]) : 32'(ax_d[a]);
                n_side.qneg[2*a+k] = slab_dist[2*a+k][32] ^ ax_d[a][31];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_nmag    <= n_nmag;
            r_dmag    <= n_dmag;
            r_side[0] <= n_side;
            for (int s = 1; s <= DIV_STAGES; s++) begin
                r_side[s] <= r_side[s-1];
            end
        end
    end

    // six slab quotients
    for (genvar q = 0; q < 6; q++) begin : g_div
        rbsi_div u_div (
            .i_clk (i_clk),
            .i_en  (en),
            .i_num ({{(DIV_BITS-49){1'b0}}, r_nmag[q], 16'h0000}),
            .i_den (r_dmag[q]),
            .o_quo (quo[q])
        );
    end

    // saturate and apply sign
    always_comb begin
        for (int q = 0; q < 6; q++) begin
            if (|quo[q][DIV_BITS-1:31]) begin
                n_t[q] = r_side[DIV_STAGES].qneg[q] ? T_SMALLEST : T_LARGEST;
            end else if (r_side[DIV_STAGES].qneg[q]) begin
                n_t[q] = -$signed({1'b0, quo[q][30:0]});
            end else begin
                n_t[q] = $signed({1'b0, quo[q][30:0]});
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_t        <= n_t;
            r_s1_pmiss <= r_side[DIV_STAGES].pmiss;
            r_s1_par   <= r_side[DIV_STAGES].par;
        end
    end

    // order the two times per axis; a parallel axis leaves the interval open
    always_comb begin
        for (int a = 0; a < 3; a++) begin
            if (r_s1_par[a]) begin
                n_lo[a] = '0;
                n_hi[a] = T_LARGEST;
            end else if (r_t[2*a] > r_t[2*a+1]) begin
                n_lo[a] = r_t[2*a+1];
                n_hi[a] = r_t[2*a];
            end else begin
                n_lo[a] = r_t[2*a];
                n_hi[a] = r_t[2*a+1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_lo       <= n_lo;
            r_hi       <= n_hi;
            r_s2_pmiss <= r_s1_pmiss;
        end
    end

    // narrow the interval over the three axes
    always_comb begin
        n_near = '0;
        n_far  = T_LARGEST;
        for (int a = 0; a < 3; a++) begin
            if (r_lo[a] > n_near) begin
                n_near = r_lo[a];
            end
            if (r_hi[a] < n_far) begin
                n_far = r_hi[a];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_near     <= n_near;
            r_far      <= n_far;
            r_s3_pmiss <= r_s2_pmiss;
        end
    end

    // hit decision and output register
    always_comb begin
        n_rsp.hit        = !r_s3_pmiss && (r_near <= r_far);
        n_rsp.entry_time = n_rsp.hit ? r_near[30:0] : 31'h0;
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_rsp <= n_rsp;
        end
    end

`ifndef SYNTHESIS
    a_miss_zero_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_rsp_valid && !o_rsp.hit) |-> (o_rsp.entry_time == 31'h0))
        else $error("miss response with nonzero entry time");

    a_ready_rule: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_req_ready == (!o_rsp_valid || i_rsp_ready))
        else $error("request ready does not follow output slot");

    a_stall_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_req_ready |=> $stable(r_v))
        else $error("pipeline valid bits moved during a stall");

    a_parallel_miss: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_v[PIPE_DEPTH-2] && en && r_s3_pmiss) |=> (o_rsp_valid && !o_rsp.hit))
        else $error("parallel-axis miss reported as hit");
`endif

endmodule

/* test/tb.sv */
// testbench for the ray / axis-aligned box slab intersection unit
module tb;
    timeunit 1ns;
    timeprecision 1ps;
    import rbsi_pkg::*;

    logic     i_clk;
    logic     i_rst_n;
    logic     i_req_valid;
    logic     o_req_ready;
    t_ray_req i_req;
    logic     o_rsp_valid;
    logic     i_rsp_ready;
    t_hit_rsp o_rsp;

    ray_box_slab_intersect_unit dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_req_valid(i_req_valid), .o_req_ready(o_req_ready), .i_req(i_req),
        .o_rsp_valid(o_rsp_valid), .i_rsp_ready(i_rsp_ready), .o_rsp(o_rsp)
    );

    t_ray_req pending_rays[$];
    t_hit_rsp expected_hits[$];
    int       mismatches = 0;
    int       rays_sent = 0;
    int       hits_seen = 0;
    int       hit_count = 0;
    bit       calm = 0;       // no idling in the last part
    bit       hold_rx = 0;    // long receiver hold-off
    bit       hold_tx = 0;    // sender pause
    int       tx_idle = 0;
    int       rx_idle = 0;

    // clock
    always begin
        i_clk = 1'b1;
        #5;
        i_clk = 1'b0;
        #5;
    end

    // slab quotient with saturation
    function automatic longint slab_quot(longint corner, longint org, longint d);
        longint q;
        q = ((corner - org) * 65536) / d;
        if (q > 64'sh7FFF_FFFF) q = 64'sh7FFF_FFFF;
        if (q < -64'sh8000_0000) q = -64'sh8000_0000;
        return q;
    endfunction

    // predicted response for one ray / box request
    function automatic t_hit_rsp predict_hit(t_ray_req r);
        longint   t_near, t_far, t1, t2, s, o, d, lo, hi;
        bit       ok;
        t_hit_rsp p;
        t_near = 0;
        t_far = 64'sh7FFF_FFFF;
        ok = 1;
        for (int a = 0; a < 3 && ok; a++) begin
            case (a)
                0: begin o = r.origin_x; d = r.dir_x; lo = r.box_min_x; hi = r.box_max_x; end
                1: begin o = r.origin_y; d = r.dir_y; lo = r.box_min_y; hi = r.box_max_y; end
                default: begin
                    o = r.origin_z; d = r.dir_z; lo = r.box_min_z; hi = r.box_max_z;
                end
            endcase
            if (d == 0) begin
                if (o < lo || o > hi) ok = 0;
            end else begin
                t1 = slab_quot(lo, o, d);
                t2 = slab_quot(hi, o, d);
                if (t1 > t2) begin s = t1; t1 = t2; t2 = s; end
                if (t1 > t_near) t_near = t1;
                if (t2 < t_far) t_far = t2;
                if (t_near > t_far) ok = 0;
            end
        end
        p.hit = ok;
        p.entry_time = ok ? t_near[30:0] : 31'd0;
        return p;
    endfunction

    // random coordinate: mostly small, sometimes full range or extreme
    function automatic logic [31:0] rnd_coord();
        case ($urandom_range(0, 9))
            0: return $urandom();
            1: return $urandom_range(0, 1) ? 32'h7FFF_FFFF : 32'h8000_0000;
            2: return 32'd0;
            default: return $signed($urandom_range(0, 32'h0028_0000)) - 32'sh0014_0000;
        endcase
    endfunction

    function automatic logic [31:0] rnd_dir();
        case ($urandom_range(0, 9))
            0: return 32'd0;
            1: return $urandom();
            2: return $urandom_range(0, 1) ? 32'h0000_0001 : 32'hFFFF_FFFF;
            default: return $signed($urandom_range(0, 32'h0004_0000)) - 32'sh0002_0000;
        endcase
    endfunction

    // random ray / box; well-formed boxes are common
    function automatic t_ray_req rnd_ray();
        t_ray_req r;
        logic signed [31:0] a, b;
        r.origin_x = rnd_coord(); r.origin_y = rnd_coord(); r.origin_z = rnd_coord();
        r.dir_x = rnd_dir(); r.dir_y = rnd_dir(); r.dir_z = rnd_dir();
        r.box_min_x = rnd_coord(); r.box_min_y = rnd_coord(); r.box_min_z = rnd_coord();
        r.box_max_x = rnd_coord(); r.box_max_y = rnd_coord(); r.box_max_z = rnd_coord();
        if ($urandom_range(0, 3) != 0) begin
            a = r.box_min_x; b = r.box_max_x;
            if (a > b) begin r.box_min_x = b; r.box_max_x = a; end
            a = r.box_min_y; b = r.box_max_y;
            if (a > b) begin r.box_min_y = b; r.box_max_y = a; end
            a = r.box_min_z; b = r.box_max_z;
            if (a > b) begin r.box_min_z = b; r.box_max_z = a; end
        end
        return r;
    endfunction

    function automatic t_ray_req mk_ray(logic [31:0] ox, oy, oz, dx, dy, dz,
                                        lx, ly, lz, hx, hy, hz);
        t_ray_req r;
        r = '{ox, oy, oz, dx, dy, dz, lx, ly, lz, hx, hy, hz};
        return r;
    endfunction

    // driver
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_req_valid <= 1'b0;
            i_req <= '0;
        end else if (!i_req_valid || o_req_ready) begin
            if (i_req_valid) begin
                expected_hits.push_back(predict_hit(i_req));
                rays_sent++;
            end
            if (tx_idle > 0) tx_idle--;
            if (!hold_tx && tx_idle == 0 && pending_rays.size() > 0
                && (calm || $urandom_range(0, 15) != 0)) begin
                i_req_valid <= 1'b1;
                i_req <= pending_rays.pop_front();
            end else begin
                i_req_valid <= 1'b0;
                if (!calm && tx_idle == 0 && $urandom_range(0, 1))
                    tx_idle = $urandom_range(1, 11);
            end
        end
    end

    // monitor and receiver stalls
    always @(posedge i_clk) begin
        t_hit_rsp e;
        if (!i_rst_n) begin
            i_rsp_ready <= 1'b0;
        end else begin
            if (o_rsp_valid && i_rsp_ready) begin
                hits_seen++;
                if (expected_hits.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10) $display("unexpected response %p", o_rsp);
                end else begin
                    e = expected_hits.pop_front();
                    if (o_rsp.hit) hit_count++;
                    if (o_rsp.hit !== e.hit || o_rsp.entry_time !== e.entry_time) begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("mismatch: hit exp %b got %b, time exp %h got %h",
                                     e.hit, o_rsp.hit, e.entry_time, o_rsp.entry_time);
                    end
                end
            end
            if (rx_idle > 0) rx_idle--;
            if (hold_rx) begin
                i_rsp_ready <= 1'b0;
            end else if (calm || (rx_idle == 0 && $urandom_range(0, 15) != 0)) begin
                i_rsp_ready <= 1'b1;
            end else begin
                i_rsp_ready <= 1'b0;
                if (rx_idle == 0) rx_idle = $urandom_range(1, 11);
            end
        end
    end

    // stimulus and end of run
    initial begin
        int n;
        i_rst_n = 1'b0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed requests: inside box, parallel axes, inverted box, extremes
        pending_rays.push_back(mk_ray(0, 0, 0, 32'h10000, 0, 0, 32'hFFFF0000, 32'hFFFF0000,
                                      32'hFFFF0000, 32'h10000, 32'h10000, 32'h10000));
        pending_rays.push_back(mk_ray(32'hFFFB0000, 0, 0, 32'h10000, 0, 0, 32'hFFFF0000,
                                      32'hFFFF0000, 32'hFFFF0000, 32'h10000, 32'h10000,
                                      32'h10000));
        pending_rays.push_back(mk_ray(32'hFFFB0000, 32'h50000, 0, 32'h10000, 0, 0,
                                      32'hFFFF0000, 32'hFFFF0000, 32'hFFFF0000, 32'h10000,
                                      32'h10000, 32'h10000));
        pending_rays.push_back(mk_ray(32'h50000, 0, 0, 32'h10000, 32'h8000, 32'hFFFF8000,
                                      32'hFFFF0000, 32'hFFFF0000, 32'hFFFF0000, 32'h10000,
                                      32'h10000, 32'h10000));
        pending_rays.push_back(mk_ray(0, 0, 0, 0, 0, 0, 32'h10000, 0, 0, 0, 0, 0));
        pending_rays.push_back(mk_ray(0, 0, 0, 32'h10000, 32'h10000, 32'h10000, 32'h10000,
                                      32'h10000, 32'h10000, 0, 0, 0));
        pending_rays.push_back(mk_ray(32'h80000000, 32'h80000000, 32'h80000000, 1, 1, 1,
                                      32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF,
                                      32'h7FFFFFFF, 32'h7FFFFFFF));
        pending_rays.push_back(mk_ray(32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF, 32'h80000000,
                                      32'h80000000, 32'h80000000, 32'h80000000, 32'h80000000,
                                      32'h80000000, 32'h80000000, 32'h80000000, 32'h80000000));
        pending_rays.push_back(mk_ray(32'hFFFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF,
                                      32'hFFFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF,
                                      32'hFFFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF));
        pending_rays.push_back(mk_ray(0, 0, 0, 32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF,
                                      32'h80000000, 32'h80000000, 32'h80000000, 32'h7FFFFFFF,
                                      32'h7FFFFFFF, 32'h7FFFFFFF));
        pending_rays.push_back(mk_ray(0, 0, 32'hFFF60000, 0, 0, 32'h10000, 32'hFFFF0000,
                                      32'hFFFF0000, 32'hFFFF0000, 32'h10000, 32'h10000,
                                      32'h10000));
        for (int i = 0; i < 14; i++) pending_rays.push_back(rnd_ray());

        // random part with a long receiver hold-off
        for (int i = 0; i < 700; i++) pending_rays.push_back(rnd_ray());
        wait (rays_sent >= 100);
        @(posedge i_clk);
        hold_rx = 1;
        repeat (200) @(posedge i_clk);
        hold_rx = 0;
        wait (pending_rays.size() == 0);

        // sender pauses until everything has drained
        hold_tx = 1;
        wait (rays_sent == 725 && !i_req_valid && expected_hits.size() == 0);
        hold_tx = 0;
        for (int i = 0; i < 600; i++) pending_rays.push_back(rnd_ray());
        wait (pending_rays.size() == 0);

        // last part without idling
        calm = 1;
        for (int i = 0; i < 325; i++) pending_rays.push_back(rnd_ray());
        wait (pending_rays.size() == 0 && (!i_req_valid || o_req_ready));
        @(posedge i_clk);
        n = 0;
        while (expected_hits.size() != 0 && n < 2000) begin
            @(posedge i_clk);
            n++;
        end
        repeat (40) @(posedge i_clk);
        $display("sent %0d ray/box requests, checked %0d responses, %0d hits",
                 rays_sent, hits_seen, hit_count);
        if (mismatches == 0 && expected_hits.size() == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

    // watchdog
    initial begin
        #2ms;
        $display("CHECK FAILED");
        $finish;
    end
endmodule
